[design/twme_pkg.sv]
// Shared types and constants for the word machine executor.
// Command and event payload structs, queue entry, opcode characters.
// No dependencies.
package twme_pkg;

    localparam int MEM_WORDS_DEF   = 100;
    localparam int BLOCK_WORDS_DEF = 10;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [2:0] EV_READ  = 3'd1;
    localparam logic [2:0] EV_PRINT = 3'd2;
    localparam logic [2:0] EV_HALT  = 3'd3;
    localparam logic [2:0] EV_ERROR = 3'd4;

    localparam logic [7:0] CH_G    = 8'h47;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_H    = 8'h48;
    localparam logic [7:0] CH_L    = 8'h4C;
    localparam logic [7:0] CH_R    = 8'h52;
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_B    = 8'h42;
    localparam logic [7:0] CH_T    = 8'h54;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] DEC_TEN = 8'd10;

    typedef struct packed {
        logic [1:0]  operation;
        logic [6:0]  word_address;
        logic [31:0] word_data;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [6:0]  target_address;
        logic [31:0] out_word;
        logic        last;
    } evt_t;

    typedef enum logic [1:0] {
        K_LOAD,
        K_START,
        K_STEP,
        K_CLEAR
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic        load_ok;
        logic [6:0]  addr;
        logic [31:0] data;
    } qent_t;

endpackage

[design/twme_front.sv]
// Front stage of the word machine executor: accepts requests and classifies them.
// Holds one classified request until the queue takes it. Uses twme_pkg.
module twme_front
    import twme_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cmd_valid,
    output logic  cmd_stall,
    input  cmd_t  cmd,
    output logic  push,
    input  logic  push_ready,
    output qent_t push_data
);

    logic  hold_valid_reg;
    logic  hold_valid_next;
    qent_t hold_reg;
    qent_t hold_next;
    logic  accept;

    assign cmd_stall = hold_valid_reg && !push_ready;
    assign accept    = cmd_valid && !cmd_stall;
    assign push      = hold_valid_reg;
    assign push_data = hold_reg;

    always_comb
    begin
        hold_next         = hold_reg;
        hold_valid_next   = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next   = 1'b1;
            hold_next.addr    = cmd.word_address;
            hold_next.data    = cmd.word_data;
            hold_next.load_ok = (cmd.word_address < 7'(MEM_WORDS));
            unique case (cmd.operation)
                OP_LOAD:  hold_next.kind = K_LOAD;
                OP_START: hold_next.kind = K_START;
                OP_STEP:  hold_next.kind = K_STEP;
                OP_CLEAR: hold_next.kind = K_CLEAR;
                default:  hold_next.kind = K_STEP;
            endcase
        end
        else if (push && push_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

[design/twme_queue.sv]
// Short request queue between front and back of the word machine executor.
// Register-based FIFO of classified requests. Uses twme_pkg.
module twme_queue
    import twme_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  push_ready,
    input  qent_t push_data,
    output logic  pop_valid,
    input  logic  pop,
    output qent_t pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    qent_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[design/twme_back.sv]
// Back stage of the word machine executor: memory, registers and instruction sequencer.
// Pops classified requests, runs them and drives the registered event output.
// Uses twme_pkg.
module twme_back
    import twme_pkg::*;
#(
    parameter int MEM_WORDS   = MEM_WORDS_DEF,
    parameter int BLOCK_WORDS = BLOCK_WORDS_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  pop_valid,
    output logic  pop,
    input  qent_t pop_data,
    output logic  evt_valid,
    input  logic  evt_stall,
    output evt_t  evt
);

    localparam int IDX_W = $clog2(MEM_WORDS);
    localparam int CNT_W = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_OPER,
        ST_PREAD,
        ST_PSEND
    } state_t;

    state_t                 state_reg, state_next;
    logic [6:0]             ic_reg, ic_next;
    logic [31:0]            gr_reg, gr_next;
    logic                   tf_reg, tf_next;
    logic                   halted_reg, halted_next;
    logic [MEM_WORDS-1:0]   vld_reg, vld_next;
    logic [6:0]             pc_reg, pc_next;
    logic [6:0]             opa_reg, opa_next;
    logic                   is_lr_reg, is_lr_next;
    logic [CNT_W-1:0]       k_reg, k_next;
    logic                   out_valid_reg, out_valid_next;
    evt_t                   out_reg, out_next;

    logic [31:0]            mem [MEM_WORDS];
    logic [31:0]            rd_reg;
    logic                   rd_vld_reg;
    logic                   mem_re;
    logic [IDX_W-1:0]       mem_raddr;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [31:0]            mem_wdata;

    logic                   out_free;
    logic                   out_load;
    logic [31:0]            rword;
    logic [7:0]             d1;
    logic [7:0]             d2;
    logic                   digits;
    logic [6:0]             dec_addr;
    logic                   is_h, is_gd, is_pd, is_lr, is_sr, is_cr, is_bt;
    logic                   known;
    logic                   bad;
    logic [6:0]             pd_addr;

    assign out_free  = !out_valid_reg || !evt_stall;
    assign evt_valid = out_valid_reg;
    assign evt       = out_reg;

    assign rword    = rd_vld_reg ? rd_reg : 32'd0;
    assign d1       = rword[15:8] - CH_0;
    assign d2       = rword[7:0] - CH_0;
    assign digits   = (d1 < DEC_TEN) && (d2 < DEC_TEN);
    assign dec_addr = 7'(d1[3:0]) * 7'd10 + 7'(d2[3:0]);
    assign is_h     = (rword[31:24] == CH_H);
    assign is_gd    = (rword[31:24] == CH_G) && (rword[23:16] == CH_D);
    assign is_pd    = (rword[31:24] == CH_P) && (rword[23:16] == CH_D);
    assign is_lr    = (rword[31:24] == CH_L) && (rword[23:16] == CH_R);
    assign is_sr    = (rword[31:24] == CH_S) && (rword[23:16] == CH_R);
    assign is_cr    = (rword[31:24] == CH_C) && (rword[23:16] == CH_R);
    assign is_bt    = (rword[31:24] == CH_B) && (rword[23:16] == CH_T);
    assign known    = is_gd || is_pd || is_lr || is_sr || is_cr || is_bt;
    assign bad      = !digits || (dec_addr >= 7'(MEM_WORDS))
                      || (is_pd && (({1'b0, dec_addr} + 8'(BLOCK_WORDS)) > 8'(MEM_WORDS)));
    assign pd_addr  = opa_reg + 7'(k_reg);

    always_comb
    begin
        state_next     = state_reg;
        ic_next        = ic_reg;
        gr_next        = gr_reg;
        tf_next        = tf_reg;
        halted_next    = halted_reg;
        vld_next       = vld_reg;
        pc_next        = pc_reg;
        opa_next       = opa_reg;
        is_lr_next     = is_lr_reg;
        k_next         = k_reg;
        out_load       = 1'b0;
        out_next       = out_reg;
        pop            = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = ic_reg[IDX_W-1:0];
        mem_we         = 1'b0;
        mem_waddr      = pop_data.addr[IDX_W-1:0];
        mem_wdata      = pop_data.data;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    unique case (pop_data.kind)
                        K_LOAD:
                        begin
                            pop = 1'b1;
                            if (pop_data.load_ok)
                            begin
                                mem_we                                = 1'b1;
                                vld_next[pop_data.addr[IDX_W-1:0]]    = 1'b1;
                            end
                        end
                        K_START:
                        begin
                            pop         = 1'b1;
                            ic_next     = '0;
                            halted_next = 1'b0;
                        end
                        K_CLEAR:
                        begin
                            pop         = 1'b1;
                            vld_next    = '0;
                            ic_next     = '0;
                            gr_next     = '0;
                            tf_next     = 1'b0;
                            halted_next = 1'b1;
                        end
                        K_STEP:
                        begin
                            if (out_free)
                            begin
                                pop = 1'b1;
                                if (halted_reg)
                                begin
                                    out_load = 1'b1;
                                    out_next = '{EV_HALT, 7'd0, 32'd0, 1'b1};
                                end
                                else if (ic_reg >= 7'(MEM_WORDS))
                                begin
                                    halted_next = 1'b1;
                                    out_load    = 1'b1;
                                    out_next    = '{EV_ERROR, ic_reg, 32'd0, 1'b1};
                                end
                                else
                                begin
                                    mem_re     = 1'b1;
                                    mem_raddr  = ic_reg[IDX_W-1:0];
                                    pc_next    = ic_reg;
                                    state_next = ST_FETCH;
                                end
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end

            ST_FETCH:
            begin
                if (out_free)
                begin
                    ic_next    = pc_reg + 7'd1;
                    state_next = ST_IDLE;
                    if (is_h)
                    begin
                        halted_next = 1'b1;
                        out_load    = 1'b1;
                        out_next    = '{EV_HALT, 7'd0, 32'd0, 1'b1};
                    end
                    else if (!known)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (bad)
                    begin
                        halted_next = 1'b1;
                        out_load    = 1'b1;
                        out_next    = '{EV_ERROR, pc_reg, rword, 1'b1};
                    end
                    else if (is_gd)
                    begin
                        if (d2[3:0] == 4'd0)
                        begin
                            out_load = 1'b1;
                            out_next = '{EV_READ, dec_addr, 32'd0, 1'b1};
                        end
                    end
                    else if (is_pd)
                    begin
                        opa_next   = dec_addr;
                        k_next     = '0;
                        state_next = ST_PREAD;
                    end
                    else if (is_lr || is_cr)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = dec_addr[IDX_W-1:0];
                        is_lr_next = is_lr;
                        state_next = ST_OPER;
                    end
                    else if (is_sr)
                    begin
                        mem_we                          = 1'b1;
                        mem_waddr                       = dec_addr[IDX_W-1:0];
                        mem_wdata                       = gr_reg;
                        vld_next[dec_addr[IDX_W-1:0]]   = 1'b1;
                    end
                    else if (tf_reg)
                    begin
                        ic_next = dec_addr;
                    end
                end
            end

            ST_OPER:
            begin
                if (is_lr_reg)
                begin
                    gr_next = rword;
                end
                else
                begin
                    tf_next = (rword == gr_reg);
                end
                state_next = ST_IDLE;
            end

            ST_PREAD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = pd_addr[IDX_W-1:0];
                state_next = ST_PSEND;
            end

            ST_PSEND:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    out_next = '{EV_PRINT, pd_addr, rword, (k_reg == CNT_W'(BLOCK_WORDS - 1))};
                    if (k_reg == CNT_W'(BLOCK_WORDS - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + CNT_W'(1);
                        state_next = ST_PREAD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!evt_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ic_reg        <= '0;
            gr_reg        <= '0;
            tf_reg        <= 1'b0;
            halted_reg    <= 1'b1;
            vld_reg       <= '0;
            pc_reg        <= '0;
            opa_reg       <= '0;
            is_lr_reg     <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ic_reg        <= ic_next;
            gr_reg        <= gr_next;
            tf_reg        <= tf_next;
            halted_reg    <= halted_next;
            vld_reg       <= vld_next;
            pc_reg        <= pc_next;
            opa_reg       <= opa_next;
            is_lr_reg     <= is_lr_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_reg     <= mem[mem_raddr];
            rd_vld_reg <= vld_reg[mem_raddr];
        end
    end

`ifndef SYNTHESIS
    a_print_running: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREAD || state_reg == ST_PSEND) |-> !halted_reg)
        else $error("print block running on a halted machine");

    a_halt_after_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (out_next.event_res == EV_HALT || out_next.event_res == EV_ERROR))
        |=> halted_reg)
        else $error("halt or error event without halted machine");

    a_fetch_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) |-> (pc_reg < 7'(MEM_WORDS)))
        else $error("fetch from out-of-range counter");

    a_oper_from_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OPER) |-> ($past(state_reg) == ST_FETCH))
        else $error("operand state entered without a fetch");
`endif

endmodule

[design/tiny_word_machine_executor_core.sv]
// Step: the back stage runs the idle and fetch (decode) states, plus an operand state for LR and
// CR, and a read and a send state per block word for PD; load, start and clear finish in idle.
// Requests pass front register and queue. Memory: single-port, registered read, one read per cycle.
// Reset is asynchronous: machine halted, counter, register and flag cleared, and all memory
// words read as zero through per-word valid bits; no clearing pass is needed.
module tiny_word_machine_executor_core
    import twme_pkg::*;
#(
    parameter int MEM_WORDS   = MEM_WORDS_DEF,
    parameter int BLOCK_WORDS = BLOCK_WORDS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic evt_valid,
    input  logic evt_stall,
    output evt_t evt
);

    logic  push;
    logic  push_ready;
    qent_t push_data;
    logic  pop_valid;
    logic  pop;
    qent_t pop_data;

    twme_front #(
        .MEM_WORDS (MEM_WORDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    twme_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data)
    );

    twme_back #(
        .MEM_WORDS   (MEM_WORDS),
        .BLOCK_WORDS (BLOCK_WORDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_data  (pop_data),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt)
    );

endmodule

[sim/testbench.sv]
// Self-checking bench for tiny_word_machine_executor_core: a directed table, then random
// programs and noise, with every event checked against a behavioral copy of the machine.
// Depends on twme_pkg and the core RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import twme_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 5;
    localparam int ITEM_TARGET  = 350;
    localparam int HOLD_AT      = 80;
    localparam int HOLD_CYCLES  = 300;
    localparam int CALM_FROM    = 180;
    localparam int CALM_TO      = 260;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 64;
    localparam int PRINT_CAP    = 40;

    typedef struct {
        cmd_t req;
        bit   typed;
        evt_t want;
    } plan_row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd       = '0;
    logic evt_valid;
    logic evt_stall = 1'b0;
    evt_t evt;

    logic hold_request = 1'b0;
    logic calm         = 1'b0;

    logic [31:0] mem_image [MEM_WORDS_DEF];
    logic [6:0]  counter_image;
    logic [31:0] reg_image;
    logic        flag_image;
    logic        halted_image;

    evt_t      awaited_events [$];
    plan_row_t plan [$];
    int requests_sent, events_checked, mismatches, idle_cycles;
    int read_seen, print_seen, halt_seen, error_seen;

    tiny_word_machine_executor_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic evt_t event_of(logic [2:0] ev, int addr, logic [31:0] word, bit fin);
        evt_t e;
        e.event_res      = ev;
        e.target_address = 7'(addr);
        e.out_word       = word;
        e.last           = fin;
        return e;
    endfunction

    function automatic cmd_t request_of(logic [1:0] op, int addr, logic [31:0] data);
        cmd_t c;
        c.operation    = op;
        c.word_address = 7'(addr);
        c.word_data    = data;
        return c;
    endfunction

    function automatic logic [31:0] encode(logic [7:0] hi, logic [7:0] lo, int addr);
        logic [7:0] tens;
        logic [7:0] ones;
        tens = CH_0 + 8'(addr / DEC_TEN);
        ones = CH_0 + 8'(addr % DEC_TEN);
        return {hi, lo, tens, ones};
    endfunction

    function automatic bit opcode_is(logic [31:0] w, logic [7:0] hi, logic [7:0] lo);
        return w[31:24] == hi && w[23:16] == lo;
    endfunction

    function automatic void clear_image();
        foreach (mem_image[i])
            mem_image[i] = '0;
        counter_image = '0;
        reg_image     = '0;
        flag_image    = 1'b0;
        halted_image  = 1'b1;
    endfunction

    function automatic void execute_step();
        logic [31:0] w;
        logic [6:0]  pc;
        logic [7:0]  tens;
        logic [7:0]  ones;
        int          addr;
        bit          is_pd;
        if (halted_image)
        begin
            awaited_events.push_back(event_of(EV_HALT, 0, '0, 1'b1));
            return;
        end
        pc = counter_image;
        if (pc >= MEM_WORDS_DEF)
        begin
            halted_image = 1'b1;
            awaited_events.push_back(event_of(EV_ERROR, pc, '0, 1'b1));
            return;
        end
        w = mem_image[pc];
        counter_image = pc + 7'd1;
        if (w[31:24] == CH_H)
        begin
            halted_image = 1'b1;
            awaited_events.push_back(event_of(EV_HALT, 0, '0, 1'b1));
            return;
        end
        if (!(opcode_is(w, CH_G, CH_D) || opcode_is(w, CH_P, CH_D) || opcode_is(w, CH_L, CH_R)
              || opcode_is(w, CH_S, CH_R) || opcode_is(w, CH_C, CH_R)
              || opcode_is(w, CH_B, CH_T)))
            return;
        tens  = w[15:8] - CH_0;
        ones  = w[7:0] - CH_0;
        addr  = int'(tens) * int'(DEC_TEN) + int'(ones);
        is_pd = opcode_is(w, CH_P, CH_D);
        if (tens >= DEC_TEN || ones >= DEC_TEN || addr >= MEM_WORDS_DEF
            || (is_pd && addr + BLOCK_WORDS_DEF > MEM_WORDS_DEF))
        begin
            halted_image = 1'b1;
            awaited_events.push_back(event_of(EV_ERROR, pc, w, 1'b1));
            return;
        end
        if (opcode_is(w, CH_G, CH_D))
        begin
            if (addr % int'(DEC_TEN) == 0)
                awaited_events.push_back(event_of(EV_READ, addr, '0, 1'b1));
        end
        else if (is_pd)
        begin
            for (int k = 0; k < BLOCK_WORDS_DEF; k++)
                awaited_events.push_back(event_of(EV_PRINT, addr + k, mem_image[addr + k],
                                                  k == BLOCK_WORDS_DEF - 1));
        end
        else if (opcode_is(w, CH_L, CH_R))
            reg_image = mem_image[addr];
        else if (opcode_is(w, CH_S, CH_R))
            mem_image[addr] = reg_image;
        else if (opcode_is(w, CH_C, CH_R))
            flag_image = (mem_image[addr] == reg_image);
        else if (flag_image)
            counter_image = 7'(addr);
    endfunction

    function automatic void execute_request(cmd_t req);
        case (req.operation)
            OP_LOAD:
                if (req.word_address < MEM_WORDS_DEF)
                    mem_image[req.word_address] = req.word_data;
            OP_START:
            begin
                counter_image = '0;
                halted_image  = 1'b0;
            end
            OP_STEP:
                execute_step();
            default:
                clear_image();
        endcase
    endfunction

    function automatic logic [31:0] random_instr(int n);
        logic [7:0] hi;
        logic [7:0] lo;
        int         addr;
        int         pick;
        bit         bad;
        pick = $urandom_range(15);
        bad  = pick >= 14;
        if (bad)
            pick = $urandom_range(11);
        addr = ($urandom_range(3) == 0) ? $urandom_range(99) : $urandom_range(19);
        case (pick)
            0, 1:
            begin
                hi = CH_G;
                lo = CH_D;
                if ($urandom_range(1) == 0)
                    addr = $urandom_range(9) * DEC_TEN;
            end
            2, 3:
            begin
                hi = CH_P;
                lo = CH_D;
                addr = ($urandom_range(7) == 0) ? $urandom_range(99, 91) : $urandom_range(90);
            end
            4, 5:
            begin
                hi = CH_L;
                lo = CH_R;
            end
            6, 7:
            begin
                hi = CH_S;
                lo = CH_R;
            end
            8, 9:
            begin
                hi = CH_C;
                lo = CH_R;
            end
            10, 11:
            begin
                hi = CH_B;
                lo = CH_T;
                if ($urandom_range(3) != 0)
                    addr = $urandom_range(n - 1);
            end
            12:
                return {CH_H, 24'($urandom)};
            default:
                return $urandom;
        endcase
        return bad ? {hi, lo, 16'($urandom)} : encode(hi, lo, addr);
    endfunction

    function automatic void plan_add(logic [1:0] op, int addr, logic [31:0] data,
                                     bit typed = 1'b0, evt_t want = '0);
        plan_row_t row;
        row.req   = request_of(op, addr, data);
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    task automatic issue(cmd_t req, bit typed = 1'b0, evt_t want = '0);
        int before_count;
        cmd       <= req;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        before_count = awaited_events.size();
        execute_request(req);
        if (typed)
        begin
            while (awaited_events.size() > before_count)
                void'(awaited_events.pop_back());
            awaited_events.push_back(want);
        end
        if (!(req.operation == OP_LOAD && req.word_address >= MEM_WORDS_DEF))
            requests_sent++;
        if (!calm && $urandom_range(99) < 20)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(4, 1))
                @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        int n;
        clear_image();
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        plan_add(OP_STEP, 0, '0, 1'b1, event_of(EV_HALT, 0, '0, 1'b1));
        plan_add(OP_LOAD, 0, encode(CH_G, CH_D, 20));
        plan_add(OP_LOAD, 1, encode(CH_G, CH_D, 25));
        plan_add(OP_LOAD, 2, encode(CH_L, CH_R, 8));
        plan_add(OP_LOAD, 3, encode(CH_S, CH_R, 90));
        plan_add(OP_LOAD, 4, encode(CH_C, CH_R, 90));
        plan_add(OP_LOAD, 5, encode(CH_P, CH_D, 90));
        plan_add(OP_LOAD, 6, {CH_G, CH_D, 8'h2F, 8'h3A});
        plan_add(OP_LOAD, 8, '1);
        plan_add(OP_START, 0, '0);
        plan_add(OP_STEP, 0, '0, 1'b1, event_of(EV_READ, 20, '0, 1'b1));
        repeat (5)
            plan_add(OP_STEP, 0, '0);
        plan_add(OP_STEP, 0, '0, 1'b1, event_of(EV_ERROR, 6, {CH_G, CH_D, 8'h2F, 8'h3A}, 1'b1));
        // branch to the last word, run past the end of memory
        plan_add(OP_LOAD, 0, encode(CH_B, CH_T, 99));
        plan_add(OP_START, 0, '0);
        plan_add(OP_STEP, 0, '0);
        plan_add(OP_STEP, 0, '0);
        plan_add(OP_STEP, 0, '0, 1'b1, event_of(EV_ERROR, MEM_WORDS_DEF, '0, 1'b1));
        plan_add(OP_LOAD, 0, encode(CH_P, CH_D, 91));
        plan_add(OP_START, 0, '0);
        plan_add(OP_STEP, 0, '0, 1'b1, event_of(EV_ERROR, 0, encode(CH_P, CH_D, 91), 1'b1));
        plan_add(OP_LOAD, 0, {CH_H, CH_0, CH_0, CH_0});
        plan_add(OP_START, 0, '0);
        plan_add(OP_STEP, 0, '0, 1'b1, event_of(EV_HALT, 0, '0, 1'b1));
        foreach (plan[i])
            issue(plan[i].req, plan[i].typed, plan[i].want);

        while (requests_sent < ITEM_TARGET)
        begin
            calm <= (requests_sent >= CALM_FROM && requests_sent < CALM_TO);
            if (requests_sent >= HOLD_AT)
                hold_request <= 1'b1;
            if ($urandom_range(99) < 15)
            begin
                repeat ($urandom_range(6, 1))
                    issue(request_of(2'($urandom), $urandom_range(127), $urandom));
            end
            else
            begin
                n = $urandom_range(12, 3);
                if ($urandom_range(99) < 30)
                    issue(request_of(OP_CLEAR, 0, '0));
                for (int i = 0; i < n; i++)
                    issue(request_of(OP_LOAD, i, random_instr(n)));
                repeat ($urandom_range(3))
                    issue(request_of(OP_LOAD, $urandom_range(99),
                                     ($urandom_range(1) == 0) ? reg_image : $urandom));
                issue(request_of(OP_START, 0, '0));
                repeat (n + $urandom_range(8))
                    issue(request_of(OP_STEP, 0, '0));
            end
        end

        cmd_valid <= 1'b0;
        while (awaited_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        $display("Sent %0d requests (directed table, random programs, noise); checked %0d events.",
                 requests_sent, events_checked);
        $display("Events by kind: %0d card reads, %0d printed words, %0d halts, %0d errors.",
                 read_seen, print_seen, halt_seen, error_seen);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : receiver
        int held;
        held = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request && held < HOLD_CYCLES)
            begin
                evt_stall <= 1'b1;
                held++;
            end
            else if (calm)
                evt_stall <= 1'b0;
            else
                evt_stall <= ($urandom_range(99) < 20);
        end
    end

    always @(posedge clk)
    begin : check_events
        evt_t want;
        if (rst_n && evt_valid && !evt_stall)
        begin
            if (awaited_events.size() == 0)
                report_mismatch($sformatf("event %0d for address %0d with nothing awaited",
                                          evt.event_res, evt.target_address));
            else
            begin
                want = awaited_events.pop_front();
                events_checked++;
                if (evt.event_res !== want.event_res)
                    report_mismatch($sformatf("event #%0d: event_res %0d, awaited %0d",
                                              events_checked, evt.event_res, want.event_res));
                if (evt.target_address !== want.target_address)
                    report_mismatch($sformatf("event #%0d: target_address %0d, awaited %0d",
                                              events_checked, evt.target_address,
                                              want.target_address));
                if (evt.out_word !== want.out_word)
                    report_mismatch($sformatf("event #%0d: out_word %h, awaited %h",
                                              events_checked, evt.out_word, want.out_word));
                if (evt.last !== want.last)
                    report_mismatch($sformatf("event #%0d: last %0b, awaited %0b",
                                              events_checked, evt.last, want.last));
            end
            case (evt.event_res)
                EV_READ:  read_seen++;
                EV_PRINT: print_seen++;
                EV_HALT:  halt_seen++;
                EV_ERROR: error_seen++;
                default:  ;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (evt_valid && !evt_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("No request moved for %0d cycles, %0d events outstanding.",
                     idle_cycles, awaited_events.size());
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

[sim.f]
design/twme_pkg.sv
design/twme_front.sv
design/twme_queue.sv
design/twme_back.sv
design/tiny_word_machine_executor_core.sv
sim/testbench.sv
